// ----- hdl/rfc_pkg.sv -----
// Shared types and constants of the response frame checker.
package rfc_pkg;

  localparam logic [7:0]  MarkA       = 8'hAA;
  localparam logic [7:0]  MarkB       = 8'h55;
  localparam logic [7:0]  LenCode     = 8'h06;
  localparam logic [3:0]  FrameBytes  = 4'd12;
  localparam logic [3:0]  PosMax      = 4'd15;
  localparam logic [15:0] ErrValue    = 16'hFFFF;

  // Byte positions inside a frame.
  localparam logic [3:0]  PosHdr0     = 4'd0;
  localparam logic [3:0]  PosHdr1     = 4'd1;
  localparam logic [3:0]  PosLen      = 4'd2;
  localparam logic [3:0]  PosDataHi   = 4'd7;
  localparam logic [3:0]  PosDataLo   = 4'd8;
  localparam logic [3:0]  PosParity   = 4'd9;
  localparam logic [3:0]  PosTrl0     = 4'd10;
  localparam logic [3:0]  PosTrl1     = 4'd11;

  // Input command codes.
  localparam logic CmdData = 1'b0;
  localparam logic CmdIdle = 1'b1;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_BAD_LENGTH  = 3'd1,
    STATUS_BAD_HEADER  = 3'd2,
    STATUS_BAD_TRAILER = 3'd3,
    STATUS_BAD_PARITY  = 3'd4
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] value;
  } result_t;

endpackage

// ----- hdl/rfc_frame_track.sv -----
// Per-frame state registers and the end-of-frame verdict.
module rfc_frame_track (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic             cmd_i,
  input  logic [7:0]       rx_byte_i,
  output rfc_pkg::result_t result_o
);

  logic [3:0]  pos_q, pos_d;
  logic [7:0]  par_q, par_d;
  logic        hdr_bad_q, hdr_bad_d;
  logic        len_bad_q, len_bad_d;
  logic        trl_bad_q, trl_bad_d;
  logic [7:0]  rx_par_q, rx_par_d;
  logic [15:0] data_q, data_d;

  always_comb begin
    pos_d     = pos_q;
    par_d     = par_q;
    hdr_bad_d = hdr_bad_q;
    len_bad_d = len_bad_q;
    trl_bad_d = trl_bad_q;
    rx_par_d  = rx_par_q;
    data_d    = data_q;
    if (take_i) begin
      if (cmd_i == rfc_pkg::CmdIdle) begin
        // Every end of frame starts a fresh frame, whatever the verdict.
        pos_d     = '0;
        par_d     = '0;
        hdr_bad_d = 1'b0;
        len_bad_d = 1'b0;
        trl_bad_d = 1'b0;
        rx_par_d  = '0;
        data_d    = '0;
      end else begin
        if (pos_q >= rfc_pkg::PosLen && pos_q <= rfc_pkg::PosDataLo) begin
          par_d = par_q ^ rx_byte_i;
        end
        case (pos_q)
          rfc_pkg::PosHdr0:   if (rx_byte_i != rfc_pkg::MarkA) hdr_bad_d = 1'b1;
          rfc_pkg::PosHdr1:   if (rx_byte_i != rfc_pkg::MarkB) hdr_bad_d = 1'b1;
          rfc_pkg::PosLen:    if (rx_byte_i != rfc_pkg::LenCode) len_bad_d = 1'b1;
          rfc_pkg::PosDataHi: data_d = {rx_byte_i, data_q[7:0]};
          rfc_pkg::PosDataLo: data_d = {data_q[15:8], rx_byte_i};
          rfc_pkg::PosParity: rx_par_d = rx_byte_i;
          rfc_pkg::PosTrl0:   if (rx_byte_i != rfc_pkg::MarkB) trl_bad_d = 1'b1;
          rfc_pkg::PosTrl1:   if (rx_byte_i != rfc_pkg::MarkA) trl_bad_d = 1'b1;
          default: ;
        endcase
        if (pos_q != rfc_pkg::PosMax) begin
          pos_d = pos_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      par_q     <= '0;
      hdr_bad_q <= 1'b0;
      len_bad_q <= 1'b0;
      trl_bad_q <= 1'b0;
      rx_par_q  <= '0;
      data_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      par_q     <= par_d;
      hdr_bad_q <= hdr_bad_d;
      len_bad_q <= len_bad_d;
      trl_bad_q <= trl_bad_d;
      rx_par_q  <= rx_par_d;
      data_q    <= data_d;
    end
  end

  // The first failing check in the order length, header, trailer, parity wins.
  always_comb begin
    if (pos_q != rfc_pkg::FrameBytes || len_bad_q) begin
      result_o.status = rfc_pkg::STATUS_BAD_LENGTH;
    end else if (hdr_bad_q) begin
      result_o.status = rfc_pkg::STATUS_BAD_HEADER;
    end else if (trl_bad_q) begin
      result_o.status = rfc_pkg::STATUS_BAD_TRAILER;
    end else if (par_q != rx_par_q) begin
      result_o.status = rfc_pkg::STATUS_BAD_PARITY;
    end else begin
      result_o.status = rfc_pkg::STATUS_OK;
    end
    result_o.value = (result_o.status == rfc_pkg::STATUS_OK) ? data_q : rfc_pkg::ErrValue;
  end

endmodule

// ----- hdl/rfc_out_buf.sv -----
// Two-entry result buffer: output register plus a skid register.
module rfc_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rfc_pkg::result_t push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rfc_pkg::result_t out_data_o
);

  logic             out_vld_q, out_vld_d;
  logic             skid_vld_q, skid_vld_d;
  rfc_pkg::result_t out_q, out_d;
  rfc_pkg::result_t skid_q, skid_d;
  logic             pop;

  assign pop = out_vld_q && !out_stall_i;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      // No push can arrive while the skid word is held.
      if (pop) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_vld_q && !pop) begin
        skid_d     = push_data_i;
        skid_vld_d = 1'b1;
      end else begin
        out_d     = push_data_i;
        out_vld_d = 1'b1;
      end
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/response_frame_checker.sv -----
// Top level of the response frame checker.
// Takes one received byte (cmd 0) or an end-of-frame mark (cmd 1) per word and
// reports one status and value word for each end-of-frame mark. A word is taken
// in every cycle in which in_stall_o is low: the frame state registers absorb
// bytes directly, and the verdict is formed by short logic from those registers
// and loaded into a two-entry output buffer. in_stall_o rises only when both
// buffer entries hold results that the downstream side has not yet taken. A
// result appears on the output in the cycle after its end-of-frame mark is
// accepted when the output register is free or being taken in that cycle;
// otherwise it waits in the second entry until the word ahead of it is taken.
module response_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] value_o
);

  logic             take;
  logic             full;
  rfc_pkg::result_t verdict;
  rfc_pkg::result_t out_data;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  rfc_frame_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .cmd_i     (cmd_i),
    .rx_byte_i (rx_byte_i),
    .result_o  (verdict)
  );

  rfc_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take && (cmd_i == rfc_pkg::CmdIdle)),
    .push_data_i (verdict),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign status_o = out_data.status;
  assign value_o  = out_data.value;

endmodule
